/* hdl/linked_fifo_index_with_limit_top_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the linked row index
// Shared concurrent checks, clocked on the rising edge, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef LINKED_FIFO_INDEX_WITH_LIMIT_TOP_MACROS_SVH
`define LINKED_FIFO_INDEX_WITH_LIMIT_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define LFI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define LFI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/lfi_pkg.sv */
// ---------------------------------------------------------------------------
// lfi_pkg
// Types and constants shared by the linked row index modules.
// ---------------------------------------------------------------------------
package lfi_pkg;

	localparam int ROW_W        = 6;
	localparam int CNT_W        = 7;
	localparam int OP_W         = 3;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 7;
	localparam int CAPACITY_DEF = 64;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 3'd0,
		OP_REMOVE = 3'd1,
		OP_CHECK  = 3'd2,
		OP_CLEAR  = 3'd3,
		OP_FIRST  = 3'd4,
		OP_NEXT   = 3'd5,
		OP_LAST   = 3'd6
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROW_LIMIT     = 2'd0,
		CFG_REVERSE_ORDER = 2'd1,
		CFG_JUMPING_MODE  = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [ROW_W-1:0] row_handle;
		logic [CNT_W-1:0] pending_here;
	} req_item_t;

	typedef struct packed {
		logic [ROW_W-1:0] row_out;
		logic             row_valid;
		logic             end_of_run;
		logic             status;
		logic [CNT_W-1:0] row_count;
	} res_item_t;

	// Link store access: one read address, one write per link array
	typedef struct packed {
		logic [ROW_W-1:0] rd_addr;
		logic             next_we;
		logic [ROW_W-1:0] next_waddr;
		logic [ROW_W-1:0] next_wdata;
		logic             prev_we;
		logic [ROW_W-1:0] prev_waddr;
		logic [ROW_W-1:0] prev_wdata;
	} link_req_t;

	typedef struct packed {
		logic [ROW_W-1:0] rd_next;
		logic [ROW_W-1:0] rd_prev;
	} link_rsp_t;

endpackage

/* hdl/lfi_link_mem.sv */
// ---------------------------------------------------------------------------
// lfi_link_mem
// Next and previous link arrays, one write each and a shared registered read.
// ---------------------------------------------------------------------------
module lfi_link_mem #(
	parameter int CAPACITY = lfi_pkg::CAPACITY_DEF
) (
	input  logic              clk,
	input  lfi_pkg::link_req_t req,
	output lfi_pkg::link_rsp_t rsp
);
	import lfi_pkg::*;

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic [IW-1:0] next_mem [CAPACITY];
	logic [IW-1:0] prev_mem [CAPACITY];

	// Write links and register the read of both arrays at one address
	always_ff @(posedge clk) begin
		if (req.next_we) begin
			next_mem[req.next_waddr[IW-1:0]] <= req.next_wdata[IW-1:0];
		end
		if (req.prev_we) begin
			prev_mem[req.prev_waddr[IW-1:0]] <= req.prev_wdata[IW-1:0];
		end
		rsp.rd_next <= ROW_W'(next_mem[req.rd_addr[IW-1:0]]);
		rsp.rd_prev <= ROW_W'(prev_mem[req.rd_addr[IW-1:0]]);
	end

endmodule

/* hdl/lfi_res_slot.sv */
// ---------------------------------------------------------------------------
// lfi_res_slot
// Single result register between the controller and the result channel.
// ---------------------------------------------------------------------------
module lfi_res_slot (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  lfi_pkg::res_item_t push_data,
	output logic               free,
	output logic               res_valid,
	input  logic               res_stall,
	output lfi_pkg::res_item_t res_data
);
	import lfi_pkg::*;

	logic      valid_q;
	res_item_t data_q;

	// Slot can take a result when empty or when its content leaves this cycle
	assign free = !valid_q || !res_stall;

	// Load on push, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			data_q  <= '0;
		end else if (push) begin
			valid_q <= 1'b1;
			data_q  <= push_data;
		end else if (!res_stall) begin
			valid_q <= 1'b0;
		end
	end

	assign res_valid = valid_q;
	assign res_data  = data_q;

endmodule

/* hdl/lfi_ctrl.sv */
// ---------------------------------------------------------------------------
// lfi_ctrl
// Request sequencer: holds head, tail, count and listed flags, updates links.
// ---------------------------------------------------------------------------
module lfi_ctrl #(
	parameter int CAPACITY = lfi_pkg::CAPACITY_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  lfi_pkg::req_item_t                  req_data,
	input  logic                                cfg_we,
	input  logic [lfi_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lfi_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	output lfi_pkg::link_req_t                  link_req,
	input  lfi_pkg::link_rsp_t                  link_rsp,
	input  logic                                slot_free,
	output logic                                push,
	output lfi_pkg::res_item_t                  push_data
);
	import lfi_pkg::*;

	`include "linked_fifo_index_with_limit_top_macros.svh"

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WALK
	} state_t;

	state_t              state_q;
	logic [OP_W-1:0]     op_q;
	logic [ROW_W-1:0]    h_q;
	logic [CNT_W-1:0]    pend_q;
	logic [ROW_W-1:0]    head_q;
	logic [ROW_W-1:0]    tail_q;
	logic [CNT_W-1:0]    count_q;
	logic [CAPACITY-1:0] listed_q;
	logic [ROW_W-1:0]    cur_q;
	logic [CNT_W-1:0]    remain_q;
	logic [CNT_W-1:0]    limit_q;
	logic                rev_q;
	logic                jump_q;

	logic             h_in_range;
	logic             h_listed;
	logic             evict;
	logic             commit;
	logic             exec_go;
	logic             walk_emit;
	logic             go_walk;
	logic             set_l;
	logic             clr_l;
	logic             clear_all;
	logic             next_en;
	logic             prev_en;
	logic [ROW_W-1:0] head_d;
	logic [ROW_W-1:0] tail_d;
	logic [CNT_W-1:0] count_d;
	res_item_t        exec_res;

	// Handle checks and the eviction test
	assign h_in_range = CNT_W'(h_q) < CNT_W'(CAPACITY);
	assign h_listed   = h_in_range && listed_q[h_q[IW-1:0]];
	assign evict      = (limit_q != '0) && (count_q >= pend_q) &&
	                    ((count_q - pend_q) >= limit_q);

	assign req_stall = (state_q != ST_IDLE);
	assign exec_go   = (state_q == ST_EXEC) && commit;
	assign walk_emit = (state_q == ST_WALK) && slot_free;

	// Work out the effect of the held request on list state and links
	always_comb begin
		head_d    = head_q;
		tail_d    = tail_q;
		count_d   = count_q;
		set_l     = 1'b0;
		clr_l     = 1'b0;
		clear_all = 1'b0;
		go_walk   = 1'b0;
		next_en   = 1'b0;
		prev_en   = 1'b0;
		link_req  = '0;
		exec_res  = '0;
		exec_res.end_of_run = 1'b1;

		unique case (op_q)
			OP_INSERT: begin
				if (!h_in_range || h_listed) begin
					exec_res.status = 1'b1;
				end else begin
					if (count_q == '0) begin
						head_d = h_q;
					end else begin
						prev_en             = 1'b1;
						link_req.prev_waddr = h_q;
						link_req.prev_wdata = tail_q;
						next_en             = 1'b1;
						link_req.next_waddr = tail_q;
						link_req.next_wdata = h_q;
					end
					tail_d  = h_q;
					set_l   = 1'b1;
					count_d = count_q + CNT_W'(1);
				end
			end
			OP_REMOVE: begin
				if (!h_listed) begin
					exec_res.status = 1'b1;
				end else begin
					if (head_q == h_q && tail_q == h_q) begin
						head_d = '0;
						tail_d = '0;
					end else if (head_q == h_q) begin
						head_d = link_rsp.rd_next;
					end else if (tail_q == h_q) begin
						tail_d = link_rsp.rd_prev;
					end else begin
						// Bridge the neighbours around the removed row
						next_en             = 1'b1;
						link_req.next_waddr = link_rsp.rd_prev;
						link_req.next_wdata = link_rsp.rd_next;
						prev_en             = 1'b1;
						link_req.prev_waddr = link_rsp.rd_next;
						link_req.prev_wdata = link_rsp.rd_prev;
					end
					clr_l   = 1'b1;
					count_d = count_q - CNT_W'(1);
				end
			end
			OP_CHECK: begin
				if (evict) begin
					if (jump_q) begin
						go_walk = 1'b1;
					end else begin
						exec_res.row_out   = head_q;
						exec_res.row_valid = 1'b1;
					end
				end
			end
			OP_CLEAR: begin
				clear_all = 1'b1;
				head_d    = '0;
				tail_d    = '0;
				count_d   = '0;
			end
			OP_FIRST, OP_LAST: begin
				if (count_q != '0) begin
					exec_res.row_valid = 1'b1;
					exec_res.row_out   = ((op_q == OP_FIRST) != rev_q) ? head_q : tail_q;
				end
			end
			OP_NEXT: begin
				if (!h_listed) begin
					exec_res.status = 1'b1;
				end else if (rev_q) begin
					if (h_q != head_q) begin
						exec_res.row_valid = 1'b1;
						exec_res.row_out   = link_rsp.rd_prev;
					end
				end else begin
					if (h_q != tail_q) begin
						exec_res.row_valid = 1'b1;
						exec_res.row_out   = link_rsp.rd_next;
					end
				end
			end
			default: begin
				exec_res.status = 1'b1;
			end
		endcase

		exec_res.row_count = count_d;
		commit             = go_walk || slot_free;
		link_req.next_we   = next_en && (state_q == ST_EXEC) && commit;
		link_req.prev_we   = prev_en && (state_q == ST_EXEC) && commit;

		// Read address: request handle, then head for a walk, then the walk itself
		unique case (state_q)
			ST_IDLE: link_req.rd_addr = req_data.row_handle;
			ST_EXEC: link_req.rd_addr = (commit && go_walk) ? head_q : h_q;
			ST_WALK: link_req.rd_addr = walk_emit ? link_rsp.rd_next : cur_q;
			default: link_req.rd_addr = h_q;
		endcase
	end

	// Result towards the slot: one per request, or one per row while walking
	always_comb begin
		push      = (exec_go && !go_walk) || walk_emit;
		push_data = exec_res;
		if (state_q == ST_WALK) begin
			push_data            = '0;
			push_data.row_out    = cur_q;
			push_data.row_valid  = 1'b1;
			push_data.end_of_run = (remain_q == CNT_W'(1));
			push_data.row_count  = count_q;
		end
	end

	// State, list registers and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			op_q     <= '0;
			h_q      <= '0;
			pend_q   <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			listed_q <= '0;
			cur_q    <= '0;
			remain_q <= '0;
			limit_q  <= '0;
			rev_q    <= 1'b0;
			jump_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ROW_LIMIT:     limit_q <= cfg_wdata;
					CFG_REVERSE_ORDER: rev_q   <= cfg_wdata[0];
					CFG_JUMPING_MODE:  jump_q  <= cfg_wdata[0];
					default: ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						op_q    <= req_data.op;
						h_q     <= req_data.row_handle;
						pend_q  <= req_data.pending_here;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (commit) begin
						head_q  <= head_d;
						tail_q  <= tail_d;
						count_q <= count_d;
						if (clear_all) begin
							listed_q <= '0;
						end else if (set_l) begin
							listed_q[h_q[IW-1:0]] <= 1'b1;
						end else if (clr_l) begin
							listed_q[h_q[IW-1:0]] <= 1'b0;
						end
						if (go_walk) begin
							cur_q    <= head_q;
							remain_q <= count_q;
							state_q  <= ST_WALK;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_WALK: begin
					if (slot_free) begin
						cur_q    <= link_rsp.rd_next;
						remain_q <= remain_q - CNT_W'(1);
						if (remain_q == CNT_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Checks on list bookkeeping
	`LFI_ASSERT_NOW(a_count_matches_flags, clk, arst_n, 1'b1, $countones(listed_q) == int'(count_q), "row count differs from listed flags")
	`LFI_ASSERT_NOW(a_ends_listed, clk, arst_n, count_q != '0, listed_q[head_q[IW-1:0]] && listed_q[tail_q[IW-1:0]], "head or tail row not listed")
	`LFI_ASSERT_NEXT(a_walk_keeps_list, clk, arst_n, state_q == ST_WALK, $stable(count_q) && $stable(head_q) && $stable(listed_q), "list changed during eviction walk")

endmodule

/* hdl/linked_fifo_index_with_limit_top.sv */
// ---------------------------------------------------------------------------
// linked_fifo_index_with_limit_top
// Insertion-ordered row index kept as a doubly linked list, with row limit.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------
//   request | into      | req_valid / req_stall | req_data   (req_item_t)
//   result  | out of    | res_valid / res_stall | res_data   (res_item_t)
//   config  | into      | cfg_we                | cfg_index, cfg_wdata
//
// Each request is accepted in an idle step that reads the link memories at
// the handle, then an update step changes links, head, tail and count and
// posts the result; a jumping eviction adds a walk, one read per row named.
// Reset clears the listed flags, head, tail and count at once; the link
// memories are not cleared and need no sweep.
// A single result register decouples res_stall; while it is full and
// stalled the block holds in its update or walk step.
// ---------------------------------------------------------------------------
module linked_fifo_index_with_limit_top #(
	parameter int CAPACITY = lfi_pkg::CAPACITY_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  lfi_pkg::req_item_t             req_data,
	output logic                           res_valid,
	input  logic                           res_stall,
	output lfi_pkg::res_item_t             res_data,
	input  logic                           cfg_we,
	input  logic [lfi_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lfi_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import lfi_pkg::*;

	link_req_t link_req;
	link_rsp_t link_rsp;
	logic      slot_free;
	logic      push;
	res_item_t push_data;

	// Sequence requests and maintain list state
	lfi_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.link_req  (link_req),
		.link_rsp  (link_rsp),
		.slot_free (slot_free),
		.push      (push),
		.push_data (push_data)
	);

	// Hold the link arrays
	lfi_link_mem #(
		.CAPACITY (CAPACITY)
	) u_link_mem (
		.clk (clk),
		.req (link_req),
		.rsp (link_rsp)
	);

	// Register results towards the consumer
	lfi_res_slot u_res_slot (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.free      (slot_free),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule
